>>> hdl/twmm_pkg.sv
package twmm_pkg;

  localparam int MAX_IDS   = 16;
  localparam int MAX_WORDS = 32;

  localparam int ID_W   = $clog2(MAX_IDS);
  localparam int CNT_W  = 6;
  localparam int HEAD_W = $clog2(MAX_WORDS);
  localparam int FILL_W = $clog2(MAX_WORDS + 1);
  localparam int POS_W  = 24;
  localparam int OFF_W  = 8;
  localparam int WL_W   = 8;
  localparam int CMD_W  = 2;
  localparam int OP_W   = 3;

  // input commands
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TOKEN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  // classified operations
  localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
  localparam logic [OP_W-1:0] OP_START = 3'd2;
  localparam logic [OP_W-1:0] OP_MISS  = 3'd3;
  localparam logic [OP_W-1:0] OP_HIT   = 3'd4;

  // configuration register indexes
  localparam logic REG_WORD_LENGTH = 1'b0;
  localparam logic REG_TOTAL_WORDS = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] req;
    logic [OFF_W-1:0] off;
  } item_t;

  typedef struct packed {
    logic              q_pop;
    logic              res_valid;
    logic [FILL_W-1:0] fill;
  } eng_status_t;

endpackage

>>> hdl/twmm_front.sv
module twmm_front import twmm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [ID_W-1:0]    token_id,
  input  logic               token_miss,
  input  logic [CNT_W-1:0]   required_count,
  input  logic [OFF_W-1:0]   phase_offset,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  item_t      entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  item_t      cls;
  logic       accept;
  logic       push;

  always_comb begin
    cls.id  = token_id;
    cls.req = required_count;
    cls.off = phase_offset;
    case (cmd)
      CMD_LOAD:  cls.op = OP_LOAD;
      CMD_TOKEN: cls.op = token_miss ? OP_MISS : OP_HIT;
      CMD_START: cls.op = OP_START;
      default:   cls.op = OP_NONE;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign accept   = in_valid && in_ready;
  // unused commands are taken and dropped here
  assign push     = accept && (cls.op != OP_NONE);
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

>>> hdl/twmm_engine.sv
module twmm_engine import twmm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  item_t            q_item,
  input  logic [WL_W-1:0]  word_length,
  input  logic [CNT_W-1:0] total_words,
  input  logic             out_free,
  output logic [POS_W-1:0] res_pos,
  output eng_status_t      status
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SLIDE = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;

  logic [1:0]        state;
  logic [CNT_W-1:0]  needed    [MAX_IDS];
  logic [CNT_W-1:0]  remaining [MAX_IDS];
  logic [ID_W-1:0]   window_ids [MAX_WORDS];
  logic [HEAD_W-1:0] head;
  logic [FILL_W-1:0] fill;
  logic [POS_W-1:0]  win_start;
  logic [POS_W-1:0]  tok_idx;
  logic [OFF_W-1:0]  cur_off;
  logic [ID_W-1:0]   cur_id;
  logic [CNT_W-1:0]  cur_rem;

  logic [ID_W-1:0]   head_id;
  logic [ID_W-1:0]   rd_id;
  logic [CNT_W-1:0]  rd_rem;
  logic [HEAD_W-1:0] tail;
  logic [FILL_W-1:0] fill_inc;
  logic              full_hit;
  logic              drop_after;
  logic              add_go;
  logic              q_pop;
  logic [31:0]       prod;
  logic [POS_W-1:0]  tok_inc;

  always_comb begin
    head_id    = window_ids[head];
    // one read port on the count table
    rd_id      = (state == ST_IDLE) ? q_item.id : head_id;
    rd_rem     = remaining[rd_id];
    tail       = head + fill[HEAD_W-1:0];
    fill_inc   = fill + FILL_W'(1);
    full_hit   = (fill_inc == FILL_W'(total_words));
    drop_after = full_hit || (fill_inc >= FILL_W'(MAX_WORDS));
    add_go     = (state == ST_SLIDE) && (cur_rem != '0) && !(full_hit && !out_free);
    q_pop      = (state == ST_IDLE) && q_valid;
    prod       = 32'(win_start) * 32'(word_length);
    res_pos    = prod[POS_W-1:0] + POS_W'(cur_off);
    tok_inc    = tok_idx + POS_W'(1);
  end

  assign status.q_pop     = q_pop;
  assign status.res_valid = add_go && full_hit;
  assign status.fill      = fill;

  always_ff @(posedge clk) begin
    if (add_go) begin
      window_ids[tail] <= cur_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      fill      <= '0;
      win_start <= '0;
      tok_idx   <= '0;
      cur_off   <= '0;
      cur_id    <= '0;
      cur_rem   <= '0;
      for (int i = 0; i < MAX_IDS; i++) begin
        needed[i]    <= '0;
        remaining[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_item.op)
              OP_LOAD: begin
                needed[q_item.id] <= q_item.req;
              end
              OP_START: begin
                cur_off   <= q_item.off;
                tok_idx   <= '0;
                win_start <= '0;
                fill      <= '0;
                head      <= '0;
                remaining <= needed;
              end
              OP_MISS: begin
                tok_idx   <= tok_inc;
                win_start <= tok_inc;
                fill      <= '0;
                head      <= '0;
                remaining <= needed;
              end
              OP_HIT: begin
                tok_idx <= tok_inc;
                cur_id  <= q_item.id;
                cur_rem <= rd_rem;
                state   <= ST_SLIDE;
              end
              default: ;
            endcase
          end
        end
        ST_SLIDE: begin
          if (cur_rem == '0) begin
            if (fill != '0) begin
              // slide the oldest entry out until the token fits
              remaining[head_id] <= rd_rem + CNT_W'(1);
              head      <= head + HEAD_W'(1);
              fill      <= fill - FILL_W'(1);
              win_start <= win_start + POS_W'(1);
              if (head_id == cur_id) begin
                cur_rem <= cur_rem + CNT_W'(1);
              end
            end else begin
              // id never fits, token dropped
              win_start <= tok_idx;
              state     <= ST_IDLE;
            end
          end else if (add_go) begin
            remaining[cur_id] <= cur_rem - CNT_W'(1);
            fill  <= fill_inc;
            state <= drop_after ? ST_DROP : ST_IDLE;
          end
        end
        ST_DROP: begin
          remaining[head_id] <= rd_rem + CNT_W'(1);
          head      <= head + HEAD_W'(1);
          fill      <= fill - FILL_W'(1);
          win_start <= win_start + POS_W'(1);
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/token_window_multiset_matcher_unit.sv
// Sliding-window multiset matcher over a stream of word-token ids. Load items set the
// required count per id, a start item opens a phase, and each token item extends the
// window; a full window reports phase_offset + start*word_length (mod 2^24) on
// match_position. A two-item queue sits between the input and the execution engine, and
// the result sits in an output register, so input keeps flowing while a result waits.
// Load, start and miss items are handled in the engine's idle state; unused commands are
// dropped at the input and never reach the engine. A token is taken in the idle state,
// then window entries are slid out to make room, then it is added, and the oldest entry
// is dropped after that when the window becomes full or reaches 32 entries; the slide
// loop reads the count table through a single port, one entry per cycle. A full window
// needing a result waits while the output register is occupied and not being read out.
// Configuration (index 0 word_length, index 1 total_words) may be written only when idle.
module token_window_multiset_matcher_unit import twmm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [ID_W-1:0]    token_id,
  input  logic               token_miss,
  input  logic [CNT_W-1:0]   required_count,
  input  logic [OFF_W-1:0]   phase_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [POS_W-1:0]   match_position,
  input  logic               write_enable,
  input  logic               write_index,
  input  logic [WL_W-1:0]    write_data
);

  logic [WL_W-1:0]  word_length;
  logic [CNT_W-1:0] total_words;
  logic             q_valid;
  item_t            q_item;
  logic             out_free;
  logic [POS_W-1:0] res_pos;
  eng_status_t      status;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= WL_W'(1);
      total_words <= CNT_W'(1);
    end else if (write_enable) begin
      case (write_index)
        REG_WORD_LENGTH: word_length <= write_data;
        REG_TOTAL_WORDS: total_words <= write_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  twmm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .token_id       (token_id),
    .token_miss     (token_miss),
    .required_count (required_count),
    .phase_offset   (phase_offset),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (status.q_pop)
  );

  twmm_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .word_length (word_length),
    .total_words (total_words),
    .out_free    (out_free),
    .res_pos     (res_pos),
    .status      (status)
  );

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (status.res_valid) begin
      match_position <= res_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    status.q_pop |-> q_valid)
    else $error("engine took an item from an empty queue");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    status.res_valid |-> (!out_valid || out_ready))
    else $error("result produced while output register still held");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    status.fill <= FILL_W'(MAX_WORDS))
    else $error("window fill beyond capacity");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    status.res_valid |=> (out_valid && match_position == $past(res_pos)))
    else $error("result not presented after it was produced");

endmodule
